@@ rtl/core/json_token_scanner_defines.svh @@
// assertion macros for the json token scanner
// the using module provides clk_i and rst_ni
`ifndef JSON_TOKEN_SCANNER_DEFINES_SVH
`define JSON_TOKEN_SCANNER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// condition holds at every edge out of reset
`define JTS_ASSERT(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("json_token_scanner: check failed");
// antecedent at one edge implies consequent at the next edge
`define JTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("json_token_scanner: sequence check failed");
`else
`define JTS_ASSERT(label, cond)
`define JTS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/core/jts_pkg.sv @@
package jts_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_NUM  = 3'd1,
    MODE_STR  = 3'd2,
    MODE_ESC  = 3'd3,
    MODE_WORD = 3'd4,
    MODE_ERR  = 3'd5
  } scan_mode_e;

  typedef enum logic [3:0] {
    KIND_COMMA    = 4'd0,
    KIND_COLON    = 4'd1,
    KIND_LCURLY   = 4'd2,
    KIND_RCURLY   = 4'd3,
    KIND_LBRACKET = 4'd4,
    KIND_RBRACKET = 4'd5,
    KIND_NUMBER   = 4'd6,
    KIND_STRING   = 4'd7,
    KIND_TRUE     = 4'd8,
    KIND_FALSE    = 4'd9,
    KIND_NULL     = 4'd10,
    KIND_EOF      = 4'd11
  } token_kind_e;

  typedef enum logic [1:0] {
    EV_BYTE = 2'd0,
    EV_DONE = 2'd1,
    EV_ERR  = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_CHAR    = 2'd1,
    ERR_ESCAPE  = 2'd2,
    ERR_KEYWORD = 2'd3
  } error_e;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_END  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0] token_kind;
    logic [1:0] event_res;
    logic [7:0] value_byte;
    logic [1:0] error_code;
    logic       last_of_run;
  } out_item_t;

  localparam int unsigned NumKeywords = 3;
  localparam logic [2:0]  CandAll     = 3'b111;
  localparam logic [2:0]  WordLenMax  = 3'd7;
  localparam int unsigned QueueDepth  = 4;

  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChN     = 8'h6e;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChT     = 8'h74;

  // keyword letters, index 0 true, 1 false, 2 null
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (k)
      2'd0: begin
        case (idx)
          3'd0: ch = 8'h74;
          3'd1: ch = 8'h72;
          3'd2: ch = 8'h75;
          3'd3: ch = 8'h65;
          default: ch = 8'h00;
        endcase
      end
      2'd1: begin
        case (idx)
          3'd0: ch = 8'h66;
          3'd1: ch = 8'h61;
          3'd2: ch = 8'h6c;
          3'd3: ch = 8'h73;
          3'd4: ch = 8'h65;
          default: ch = 8'h00;
        endcase
      end
      2'd2: begin
        case (idx)
          3'd0: ch = 8'h6e;
          3'd1: ch = 8'h75;
          3'd2: ch = 8'h6c;
          3'd3: ch = 8'h6c;
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] len;
    case (k)
      2'd0: len = 3'd4;
      2'd1: len = 3'd5;
      2'd2: len = 3'd4;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/core/json_token_scanner.sv @@
// json token scanner: one source byte or end marker per item
// path: an accepted item is held in the input register and decoded there; its results
//   are written into the result queue and offered from it; decoding waits for queue room
// throughput: one item per cycle while each item gives at most one result and the sink takes
//   it; an item with two results uses the single result port twice
// reset: scanner idle, number_charset = 1, input stage and result queue empty
module json_token_scanner
  import jts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  // configuration
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  // source side
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  // result side
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

`include "json_token_scanner_defines.svh"

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  // configuration register
  logic number_charset_q;

  // input register
  logic     in_valid_q, in_valid_d;
  in_item_t in_item_q;

  // scanner state
  scan_mode_e mode_q, mode_d;
  logic [2:0] wlen_q, wlen_d;
  logic [2:0] cand_q, cand_d;

  // result queue
  out_item_t           queue_q [QueueDepth];
  logic [PtrW-1:0]     wptr_q, rptr_q;
  logic [CntW-1:0]     cnt_q, cnt_d;

  logic       accept, proc_fire, pop;
  logic [7:0] ch;
  logic       is_end;

  // byte classes
  logic       is_ws, is_punct, is_digit, is_num, is_alpha, is_quote, is_bslash, esc_ok;
  logic [3:0] punct_kind;

  // letter run helpers
  logic [2:0] cand_add, wlen_add;
  logic       kw_hit;
  logic [3:0] kw_kind;

  // start of a new token from the current byte
  logic       st_emit;
  out_item_t  st_res;
  scan_mode_e st_mode;
  logic       st_word;

  // results of this item, before and after marking the last one
  out_item_t  res0_raw, res1_raw, res0, res1;
  logic [1:0] push_n;

  // a new item enters once the input register is free or drains this cycle
  assign proc_fire  = in_valid_q && (cnt_q <= CntW'(QueueDepth - 2));
  assign in_stall_o = in_valid_q && !proc_fire;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_valid_d = accept ? 1'b1 : (proc_fire ? 1'b0 : in_valid_q);

  assign ch     = in_item_q.byte_value;
  assign is_end = (in_item_q.cmd == CMD_END);

  // character classification
  always_comb begin
    is_ws      = (ch == 8'h20) || (ch == 8'h09) || (ch == 8'h0a) || (ch == 8'h0d);
    is_punct   = 1'b1;
    punct_kind = KIND_COMMA;
    case (ch)
      8'h2c: punct_kind = KIND_COMMA;
      8'h3a: punct_kind = KIND_COLON;
      8'h7b: punct_kind = KIND_LCURLY;
      8'h7d: punct_kind = KIND_RCURLY;
      8'h5b: punct_kind = KIND_LBRACKET;
      8'h5d: punct_kind = KIND_RBRACKET;
      default: is_punct = 1'b0;
    endcase
    is_digit  = (ch >= 8'h30) && (ch <= 8'h39);
    // the sign, dot and exponent letters count only with the wide charset
    is_num    = is_digit || (number_charset_q &&
                ((ch == 8'h2d) || (ch == 8'h2b) || (ch == 8'h2e) ||
                 (ch == 8'h65) || (ch == 8'h45)));
    is_alpha  = ((ch >= 8'h61) && (ch <= 8'h7a)) || ((ch >= 8'h41) && (ch <= 8'h5a));
    is_quote  = (ch == 8'h22);
    is_bslash = (ch == 8'h5c);
    esc_ok    = is_bslash || is_quote || (ch == ChSlash) || (ch == ChB) ||
                (ch == ChF) || (ch == ChN) || (ch == ChR) || (ch == ChT);
  end

  // keyword match, one letter per item, each keyword dropped on its first mismatch
  always_comb begin
    cand_add = cand_q;
    for (int k = 0; k < NumKeywords; k++) begin
      if ((wlen_q >= kw_len(2'(k))) || (kw_char(2'(k), wlen_q) != ch)) begin
        cand_add[k] = 1'b0;
      end
    end
    wlen_add = (wlen_q == WordLenMax) ? WordLenMax : wlen_q + 3'd1;

    // closing check, first full match in keyword order
    kw_hit  = 1'b0;
    kw_kind = KIND_TRUE;
    if (cand_q[0] && (wlen_q == kw_len(2'd0))) begin
      kw_hit  = 1'b1;
      kw_kind = KIND_TRUE;
    end else if (cand_q[1] && (wlen_q == kw_len(2'd1))) begin
      kw_hit  = 1'b1;
      kw_kind = KIND_FALSE;
    end else if (cand_q[2] && (wlen_q == kw_len(2'd2))) begin
      kw_hit  = 1'b1;
      kw_kind = KIND_NULL;
    end
  end

  // what the current byte does between tokens
  always_comb begin
    st_emit = 1'b0;
    st_res  = '0;
    st_mode = MODE_IDLE;
    st_word = 1'b0;
    if (is_ws) begin
      st_mode = MODE_IDLE;
    end else if (is_punct) begin
      st_emit = 1'b1;
      st_res.token_kind = punct_kind;
      st_res.event_res  = EV_DONE;
    end else if (is_num) begin
      st_emit = 1'b1;
      st_res.token_kind = KIND_NUMBER;
      st_res.event_res  = EV_BYTE;
      st_res.value_byte = ch;
      st_mode = MODE_NUM;
    end else if (is_alpha) begin
      st_word = 1'b1;
      st_mode = MODE_WORD;
    end else if (is_quote) begin
      st_mode = MODE_STR;
    end else begin
      st_emit = 1'b1;
      st_res.event_res  = EV_ERR;
      st_res.error_code = ERR_CHAR;
      st_mode = MODE_ERR;
    end
  end

  // next scanner state
  always_comb begin
    mode_d = mode_q;
    wlen_d = wlen_q;
    cand_d = cand_q;
    if (proc_fire) begin
      if (is_end) begin
        mode_d = MODE_IDLE;
        wlen_d = '0;
        cand_d = CandAll;
      end else begin
        case (mode_q)
          MODE_NUM: begin
            if (!is_num) begin
              mode_d = st_mode;
            end
          end
          MODE_STR: begin
            if (is_quote) begin
              mode_d = MODE_IDLE;
            end else if (is_bslash) begin
              mode_d = MODE_ESC;
            end
          end
          MODE_ESC: begin
            mode_d = esc_ok ? MODE_STR : MODE_ERR;
          end
          MODE_WORD: begin
            if (is_alpha) begin
              wlen_d = wlen_add;
              cand_d = cand_add;
            end else if (kw_hit) begin
              mode_d = st_mode;
            end else begin
              mode_d = MODE_ERR;
            end
          end
          MODE_ERR: begin
            mode_d = MODE_ERR;
          end
          default: begin
            mode_d = st_mode;
          end
        endcase
        // a letter that starts a run seeds the keyword match
        if (st_word && ((mode_q == MODE_IDLE) || (mode_q == MODE_NUM && !is_num) ||
                        (mode_q == MODE_WORD && !is_alpha && kw_hit) ||
                        (mode_q != MODE_NUM && mode_q != MODE_STR && mode_q != MODE_ESC &&
                         mode_q != MODE_WORD && mode_q != MODE_ERR))) begin
          wlen_d = 3'd1;
          cand_d = {ch == 8'h6e, ch == 8'h66, ch == 8'h74};
        end
      end
    end
  end

  // results of the current item
  always_comb begin
    res0_raw = '0;
    res1_raw = '0;
    push_n   = 2'd0;
    if (proc_fire) begin
      if (is_end) begin
        // close the open token, then eof unless the close was an error
        res1_raw.token_kind = KIND_EOF;
        res1_raw.event_res  = EV_DONE;
        case (mode_q)
          MODE_NUM: begin
            res0_raw.token_kind = KIND_NUMBER;
            res0_raw.event_res  = EV_DONE;
            push_n = 2'd2;
          end
          MODE_STR: begin
            res0_raw.token_kind = KIND_STRING;
            res0_raw.event_res  = EV_DONE;
            push_n = 2'd2;
          end
          MODE_ESC: begin
            res0_raw.event_res  = EV_ERR;
            res0_raw.error_code = ERR_ESCAPE;
            push_n = 2'd1;
          end
          MODE_WORD: begin
            if (kw_hit) begin
              res0_raw.token_kind = kw_kind;
              res0_raw.event_res  = EV_DONE;
              push_n = 2'd2;
            end else begin
              res0_raw.event_res  = EV_ERR;
              res0_raw.error_code = ERR_KEYWORD;
              push_n = 2'd1;
            end
          end
          MODE_ERR: begin
            push_n = 2'd0;
          end
          default: begin
            res0_raw = res1_raw;
            push_n   = 2'd1;
          end
        endcase
      end else begin
        case (mode_q)
          MODE_NUM: begin
            if (is_num) begin
              res0_raw.token_kind = KIND_NUMBER;
              res0_raw.event_res  = EV_BYTE;
              res0_raw.value_byte = ch;
              push_n = 2'd1;
            end else begin
              res0_raw.token_kind = KIND_NUMBER;
              res0_raw.event_res  = EV_DONE;
              res1_raw = st_res;
              push_n = st_emit ? 2'd2 : 2'd1;
            end
          end
          MODE_STR: begin
            res0_raw.token_kind = KIND_STRING;
            res0_raw.event_res  = is_quote ? EV_DONE : EV_BYTE;
            res0_raw.value_byte = is_quote ? 8'h00 : ch;
            push_n = 2'd1;
          end
          MODE_ESC: begin
            if (esc_ok) begin
              res0_raw.token_kind = KIND_STRING;
              res0_raw.event_res  = EV_BYTE;
              res0_raw.value_byte = ch;
            end else begin
              res0_raw.event_res  = EV_ERR;
              res0_raw.error_code = ERR_ESCAPE;
            end
            push_n = 2'd1;
          end
          MODE_WORD: begin
            if (is_alpha) begin
              push_n = 2'd0;
            end else if (kw_hit) begin
              res0_raw.token_kind = kw_kind;
              res0_raw.event_res  = EV_DONE;
              res1_raw = st_res;
              push_n = st_emit ? 2'd2 : 2'd1;
            end else begin
              // the byte that closed the failed run is dropped
              res0_raw.event_res  = EV_ERR;
              res0_raw.error_code = ERR_KEYWORD;
              push_n = 2'd1;
            end
          end
          MODE_ERR: begin
            push_n = 2'd0;
          end
          default: begin
            res0_raw = st_res;
            push_n   = st_emit ? 2'd1 : 2'd0;
          end
        endcase
      end
    end
    res0 = res0_raw;
    res1 = res1_raw;
    res0.last_of_run = (push_n == 2'd1);
    res1.last_of_run = (push_n == 2'd2);
  end

  // result queue, up to two writes and one read per cycle
  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = queue_q[rptr_q];
  assign cnt_d       = cnt_q + CntW'(push_n) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_item_i;
    end
    if (push_n != 2'd0) begin
      queue_q[wptr_q] <= res0;
    end
    if (push_n == 2'd2) begin
      queue_q[wptr_q + PtrW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_charset_q <= 1'b1;
      in_valid_q       <= 1'b0;
      mode_q           <= MODE_IDLE;
      wlen_q           <= '0;
      cand_q           <= CandAll;
      wptr_q           <= '0;
      rptr_q           <= '0;
      cnt_q            <= '0;
    end else begin
      if (cfg_we_i) begin
        number_charset_q <= cfg_wdata_i;
      end
      in_valid_q <= in_valid_d;
      mode_q     <= mode_d;
      wlen_q     <= wlen_d;
      cand_q     <= cand_d;
      wptr_q     <= wptr_q + PtrW'(push_n);
      rptr_q     <= rptr_q + PtrW'(pop);
      cnt_q      <= cnt_d;
    end
  end

  // checks on the scanner and its queue
  `JTS_ASSERT(a_queue_bound, cnt_q <= CntW'(QueueDepth))
  `JTS_ASSERT(a_err_silent, !(proc_fire && !is_end && mode_q == MODE_ERR) || push_n == 2'd0)
  `JTS_ASSERT_NEXT(a_end_idle, proc_fire && is_end, mode_q == MODE_IDLE && cand_q == CandAll)
  `JTS_ASSERT(a_ptr_gap, (wptr_q - rptr_q) == cnt_q[PtrW-1:0])

endmodule

@@ dv/json_token_scanner_test.sv @@
module json_token_scanner_test;
  timeunit 1ns;
  timeprecision 1ps;
  import jts_pkg::*;

  // run shape
  localparam int StallLimit  = 1000;  // cycles with no item moving on either side
  localparam int HoldCycles  = 200;   // long receiver hold-off in the pressure phase
  localparam int SettleCycles = 6;    // settle time after the expected results have drained
  localparam int PhaseItems  = 300;
  localparam int NumPhases   = 6;

  // error results carry token kind zero
  localparam token_kind_e KindOnErr = KIND_COMMA;

  // whitespace bytes
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;

  // per phase: number charset, sender idle percent, receiver stall percent, long hold
  int phase_charset [NumPhases] = '{0, 1, 0, 1, 1, 0};
  int phase_src_idle [NumPhases] = '{0, 58, 0, 17, 0, 58};
  int phase_sink_stall [NumPhases] = '{0, 0, 58, 17, 0, 58};
  int phase_hold [NumPhases] = '{0, 0, 0, 0, 1, 0};

  string keywords [3] = '{"true", "false", "null"};

  // dut ports, all inputs known from time zero
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic      cfg_wdata_i = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  json_token_scanner DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // tokenizer prediction: private copy of register and scan state
  // ---------------------------------------------------------------------------
  logic       charset_q;
  scan_mode_e mode_q;
  logic [2:0] wlen_q;
  logic [2:0] cand_q;

  // results caused by the item just scanned
  out_item_t  tok_buf [2];
  int         tok_cnt;

  // expected results, oldest first
  out_item_t  token_q [$];

  // source items of the current phase
  in_item_t   src_q [$];

  int n_fail = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int holds_asked = 0;

  function automatic void put_tok(token_kind_e k, event_e e, logic [7:0] b, error_e er);
    out_item_t r;
    r.token_kind  = k;
    r.event_res   = e;
    r.value_byte  = b;
    r.error_code  = er;
    r.last_of_run = 1'b0;
    tok_buf[tok_cnt] = r;
    tok_cnt++;
  endfunction

  function automatic bit num_char(logic [7:0] c);
    if (c >= "0" && c <= "9") return 1'b1;
    return charset_q && (c == "-" || c == "+" || c == "." || c == "e" || c == "E");
  endfunction

  function automatic bit letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // narrow the keyword candidates by one more letter
  function automatic void word_push(logic [7:0] c);
    for (int k = 0; k < 3; k++) begin
      if (wlen_q >= keywords[k].len() || keywords[k].getc(wlen_q) != c) cand_q[k] = 1'b0;
    end
    if (wlen_q < WordLenMax) wlen_q++;
  endfunction

  // full match gives a keyword token, anything else a keyword error
  function automatic bit word_close();
    for (int k = 0; k < 3; k++) begin
      if (cand_q[k] && wlen_q == keywords[k].len()) begin
        put_tok(token_kind_e'(KIND_TRUE + k), EV_DONE, 8'h00, ERR_NONE);
        return 1'b1;
      end
    end
    put_tok(KindOnErr, EV_ERR, 8'h00, ERR_KEYWORD);
    return 1'b0;
  endfunction

  // byte seen between tokens
  function automatic void token_start(logic [7:0] c);
    mode_q = MODE_IDLE;
    case (c)
      ChSpace, ChTab, ChLf, ChCr: ;
      ",": put_tok(KIND_COMMA, EV_DONE, 8'h00, ERR_NONE);
      ":": put_tok(KIND_COLON, EV_DONE, 8'h00, ERR_NONE);
      "{": put_tok(KIND_LCURLY, EV_DONE, 8'h00, ERR_NONE);
      "}": put_tok(KIND_RCURLY, EV_DONE, 8'h00, ERR_NONE);
      "[": put_tok(KIND_LBRACKET, EV_DONE, 8'h00, ERR_NONE);
      "]": put_tok(KIND_RBRACKET, EV_DONE, 8'h00, ERR_NONE);
      default: begin
        if (num_char(c)) begin
          put_tok(KIND_NUMBER, EV_BYTE, c, ERR_NONE);
          mode_q = MODE_NUM;
        end else if (letter(c)) begin
          wlen_q = '0;
          cand_q = CandAll;
          word_push(c);
          mode_q = MODE_WORD;
        end else if (c == "\"") begin
          mode_q = MODE_STR;
        end else begin
          put_tok(KindOnErr, EV_ERR, 8'h00, ERR_CHAR);
          mode_q = MODE_ERR;
        end
      end
    endcase
  endfunction

  // end marker: close what is open, then eof unless an error came up
  function automatic void source_end();
    bit eof;
    eof = 1'b1;
    case (mode_q)
      MODE_NUM: put_tok(KIND_NUMBER, EV_DONE, 8'h00, ERR_NONE);
      MODE_STR: put_tok(KIND_STRING, EV_DONE, 8'h00, ERR_NONE);
      MODE_ESC: begin
        put_tok(KindOnErr, EV_ERR, 8'h00, ERR_ESCAPE);
        eof = 1'b0;
      end
      MODE_WORD: eof = word_close();
      MODE_ERR: eof = 1'b0;
      default: ;
    endcase
    if (eof) put_tok(KIND_EOF, EV_DONE, 8'h00, ERR_NONE);
    mode_q = MODE_IDLE;
    wlen_q = '0;
    cand_q = CandAll;
  endfunction

  function automatic void source_byte(logic [7:0] c);
    case (mode_q)
      MODE_NUM: begin
        if (num_char(c)) begin
          put_tok(KIND_NUMBER, EV_BYTE, c, ERR_NONE);
        end else begin
          put_tok(KIND_NUMBER, EV_DONE, 8'h00, ERR_NONE);
          token_start(c);
        end
      end
      MODE_STR: begin
        if (c == "\"") begin
          put_tok(KIND_STRING, EV_DONE, 8'h00, ERR_NONE);
          mode_q = MODE_IDLE;
        end else begin
          put_tok(KIND_STRING, EV_BYTE, c, ERR_NONE);
          if (c == "\\") mode_q = MODE_ESC;
        end
      end
      MODE_ESC: begin
        case (c)
          "\\", "\"", ChSlash, ChB, ChF, ChN, ChR, ChT: begin
            put_tok(KIND_STRING, EV_BYTE, c, ERR_NONE);
            mode_q = MODE_STR;
          end
          default: begin
            put_tok(KindOnErr, EV_ERR, 8'h00, ERR_ESCAPE);
            mode_q = MODE_ERR;
          end
        endcase
      end
      MODE_WORD: begin
        // the byte that closes a bad letter run is dropped
        if (letter(c)) word_push(c);
        else if (word_close()) token_start(c);
        else mode_q = MODE_ERR;
      end
      MODE_ERR: ;
      default: token_start(c);
    endcase
  endfunction

  // one accepted item: fills tok_buf, last result gets last_of_run
  function automatic void lex_item(in_item_t it);
    tok_cnt = 0;
    if (it.cmd == CMD_END) source_end();
    else source_byte(it.byte_value);
    if (tok_cnt > 0) tok_buf[tok_cnt-1].last_of_run = 1'b1;
  endfunction

  function automatic void queue_predicted();
    for (int i = 0; i < tok_cnt; i++) token_q.push_back(tok_buf[i]);
  endfunction

  // typed expectation for single-result directed rows
  function automatic out_item_t tok(token_kind_e k, event_e e, error_e er);
    out_item_t r;
    r.token_kind  = k;
    r.event_res   = e;
    r.value_byte  = 8'h00;
    r.error_code  = er;
    r.last_of_run = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // random source text: mostly json-like tokens, some noise and end markers
  // ---------------------------------------------------------------------------
  function automatic void push_byte(logic [7:0] b);
    in_item_t it;
    it.cmd        = CMD_BYTE;
    it.byte_value = b;
    src_q.push_back(it);
  endfunction

  function automatic void gen_fragment();
    int         pick;
    int         n;
    int         r;
    logic [7:0] c;
    string      w;
    logic [7:0] ws_set [4];
    string      punct_set;
    string      num_extra;
    string      esc_ok;
    in_item_t   it;
    ws_set    = '{ChSpace, ChTab, ChLf, ChCr};
    punct_set = ",:{}[]";
    num_extra = "-+.eE";
    esc_ok    = "\\\"/bfnrt";
    pick = $urandom_range(99);
    if (pick < 12) begin
      // whitespace run
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) push_byte(ws_set[$urandom_range(3)]);
    end else if (pick < 30) begin
      push_byte(punct_set.getc($urandom_range(5)));
    end else if (pick < 48) begin
      // number text, sign and exponent chars only count with the wide charset
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(3) == 0) push_byte(num_extra.getc($urandom_range(4)));
        else push_byte(8'("0" + $urandom_range(9)));
      end
    end else if (pick < 68) begin
      // string with printable text, escapes, raw bytes, now and then a bad escape
      push_byte("\"");
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(9);
        if (r < 6) begin
          c = 8'($urandom_range(8'h20, 8'h7e));
          if (c == "\"" || c == "\\") c = "a";
          push_byte(c);
        end else if (r < 8) begin
          push_byte("\\");
          push_byte(esc_ok.getc($urandom_range(7)));
        end else if (r == 8) begin
          push_byte(8'($urandom_range(255)));
        end else begin
          push_byte("\\");
          push_byte(8'($urandom_range(255)));
        end
      end
      // unterminated now and then
      if ($urandom_range(9) != 0) push_byte("\"");
    end else if (pick < 84) begin
      // keyword, sometimes with a case flip, cut short or run on
      w = keywords[$urandom_range(2)];
      r = $urandom_range(9);
      if (r == 0) begin
        n = $urandom_range(w.len() - 1);
        w.putc(n, w.getc(n) ^ 8'h20);
      end else if (r == 1) begin
        w = w.substr(0, w.len() - 2);
      end else if (r == 2) begin
        w = {w, "s"};
      end else if (r == 3) begin
        w = {w, "xyzXYZ"};
      end
      for (int i = 0; i < w.len(); i++) push_byte(w.getc(i));
    end else if (pick < 96) begin
      push_byte(8'($urandom_range(255)));
    end else begin
      it.cmd        = CMD_END;
      it.byte_value = 8'($urandom_range(255));
      src_q.push_back(it);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // source side driver, called at a falling edge, returns at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    lex_item(it);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (token_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls plus a long hold-off when asked
  // ---------------------------------------------------------------------------
  initial begin
    int holds_done;
    int hold_left;
    holds_done = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && holds_asked > holds_done) begin
        hold_left = HoldCycles;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < sink_stall_pct);
      end
    end
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (token_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("unexpected result: kind %0d ev %0d byte %02h err %0d last %0b",
                   out_item_o.token_kind, out_item_o.event_res, out_item_o.value_byte,
                   out_item_o.error_code, out_item_o.last_of_run);
      end else begin
        want = token_q.pop_front();
        if (out_item_o !== want) begin
          n_fail++;
          if (n_fail <= 10)
            $display("mismatch: exp %0d/%0d/%02h/%0d/%0b got %0d/%0d/%02h/%0d/%0b",
                     want.token_kind, want.event_res, want.value_byte,
                     want.error_code, want.last_of_run,
                     out_item_o.token_kind, out_item_o.event_res, out_item_o.value_byte,
                     out_item_o.error_code, out_item_o.last_of_run);
        end
      end
    end
  end

  // watchdog on cycles where no item moves
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("json_token_scanner_test: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // directed rows: item, whether the expectation is typed in, how many results, and that expectation
  // ---------------------------------------------------------------------------
  typedef struct {
    in_item_t  item;
    bit        typed;
    int        n;
    out_item_t e0;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic void add_row(cmd_e c, logic [7:0] b, bit typed = 1'b0, int n = 0,
                                  out_item_t e0 = '0);
    dir_row_t row;
    row.item.cmd        = c;
    row.item.byte_value = b;
    row.typed           = typed;
    row.n               = n;
    row.e0              = e0;
    dir_rows.push_back(row);
  endfunction

  initial begin
    dir_row_t row;
    // predictor starts from the reset state
    charset_q = 1'b1;
    mode_q    = MODE_IDLE;
    wlen_q    = '0;
    cand_q    = CandAll;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // end of source right after reset gives eof alone
    add_row(CMD_END, 8'hff, 1'b1, 1, tok(KIND_EOF, EV_DONE, ERR_NONE));
    add_row(CMD_BYTE, "{", 1'b1, 1, tok(KIND_LCURLY, EV_DONE, ERR_NONE));
    // string: escape kept with its backslash, zero and top byte are plain text
    add_row(CMD_BYTE, "\"");
    add_row(CMD_BYTE, "\\");
    add_row(CMD_BYTE, ChSlash);
    add_row(CMD_BYTE, 8'h00);
    add_row(CMD_BYTE, 8'hff);
    add_row(CMD_BYTE, "\"");
    add_row(CMD_BYTE, ":", 1'b1, 1, tok(KIND_COLON, EV_DONE, ERR_NONE));
    // keyword closed by punctuation, two results
    add_row(CMD_BYTE, "n");
    add_row(CMD_BYTE, "u");
    add_row(CMD_BYTE, "l");
    add_row(CMD_BYTE, "l");
    add_row(CMD_BYTE, ",");
    // number closed by bracket
    add_row(CMD_BYTE, "9");
    add_row(CMD_BYTE, "E");
    add_row(CMD_BYTE, "]");
    // letter run with no match closed by the end marker, no eof
    add_row(CMD_BYTE, "T");
    add_row(CMD_END, 8'h00, 1'b1, 1, tok(KindOnErr, EV_ERR, ERR_KEYWORD));
    // end right after a backslash, no eof
    add_row(CMD_BYTE, "\"");
    add_row(CMD_BYTE, "\\");
    add_row(CMD_END, 8'h00, 1'b1, 1, tok(KindOnErr, EV_ERR, ERR_ESCAPE));
    // byte zero between tokens, then bytes and end ignored while in error
    add_row(CMD_BYTE, 8'h00, 1'b1, 1, tok(KindOnErr, EV_ERR, ERR_CHAR));
    add_row(CMD_BYTE, 8'hff, 1'b1, 0);
    add_row(CMD_END, 8'h55, 1'b1, 0);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_item(row.item);
      if (!row.typed) queue_predicted();
      else if (row.n > 0) token_q.push_back(row.e0);
    end

    for (int p = 0; p < NumPhases; p++) begin
      // settle, then switch the charset while nothing is in flight
      in_valid_i <= 1'b0;
      wait_drained();
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= phase_charset[p][0];
      charset_q   = phase_charset[p][0];
      @(negedge clk_i);
      cfg_we_i <= 1'b0;

      src_idle_pct   = phase_src_idle[p];
      sink_stall_pct = phase_sink_stall[p];
      // receiver holds off while the sender keeps offering, so the block backs up
      if (phase_hold[p] != 0) holds_asked++;

      src_q.delete();
      while (src_q.size() < PhaseItems) gen_fragment();
      // close the phase with an end marker
      begin
        in_item_t last_it;
        last_it.cmd        = CMD_END;
        last_it.byte_value = 8'h00;
        src_q.push_back(last_it);
      end
      while (src_q.size() != 0) begin
        send_item(src_q.pop_front());
        queue_predicted();
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    if (n_fail == 0) $display("json_token_scanner_test: clean");
    else $display("json_token_scanner_test: errors");
    $finish;
  end

endmodule
